// ===== rtl/dst_pkg.sv =====
// Shared types and constants for the delimiter split tokenizer.
// No dependencies; imported by every module of the block.
`default_nettype none

package dst_pkg;

    localparam int FIELD_BITS     = 16;
    localparam int CFG_INDEX_BITS = 4;
    localparam int CFG_DATA_BITS  = 64;
    localparam int LEN_REG_BITS   = 4;
    localparam int FIFO_DEPTH     = 4;
    localparam int FIFO_PTR_BITS  = 2;
    localparam int FIFO_CNT_BITS  = 3;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_DELIMITER_BYTES  = 4'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_DELIMITER_LENGTH = 4'd1;

    localparam logic [CFG_DATA_BITS-1:0] DELIM_BYTES_RESET = 64'd44;
    localparam logic [LEN_REG_BITS-1:0]  DELIM_LEN_RESET   = 4'd1;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_present;
        logic       end_of_string;
    } in_item_t;

    typedef struct packed {
        logic [FIELD_BITS-1:0] field_start;
        logic [FIELD_BITS-1:0] field_length;
        logic                  last_field;
        logic                  position_overflow;
    } result_t;

    // Results raised by one accepted item: count is 0, 1 or 2.
    typedef struct packed {
        logic [1:0] count;
        result_t    first;
        result_t    second;
    } push_t;

endpackage

`default_nettype wire

// ===== rtl/dst_match.sv =====
// Parallel delimiter compare over the byte window, one compare per lane.
// Depends on dst_pkg.
`default_nettype none

module dst_match #(
    parameter int MAX_DELIMITER_BYTES = 8,
    parameter int LEN_W               = 4
) (
    input  wire logic [MAX_DELIMITER_BYTES-1:0][7:0] window,
    input  wire logic [MAX_DELIMITER_BYTES-1:0][7:0] delim,
    input  wire logic [LEN_W-1:0]                    len,
    output logic                                     hit
);
    import dst_pkg::*;

    // window[0] is the newest byte, so it meets the last delimiter byte
    always_comb begin
        logic ok;
        hit = 1'b0;
        for (int l = 1; l <= MAX_DELIMITER_BYTES; l++) begin
            ok = 1'b1;
            for (int j = 0; j < l; j++) begin
                if (window[j] != delim[l-1-j]) begin
                    ok = 1'b0;
                end
            end
            if (len == LEN_W'(l) && ok) begin
                hit = 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/dst_fifo.sv =====
// Four-entry result queue taking up to two results per cycle, one out per beat.
// Depends on dst_pkg.
`default_nettype none

module dst_fifo (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire dst_pkg::push_t   push,
    output logic                  room,
    output logic                  m_valid,
    input  wire logic             m_ready,
    output dst_pkg::result_t      m_data
);
    import dst_pkg::*;

    result_t                  mem [FIFO_DEPTH];
    logic [FIFO_PTR_BITS-1:0] wr_ptr_reg, wr_ptr_next;
    logic [FIFO_PTR_BITS-1:0] rd_ptr_reg, rd_ptr_next;
    logic [FIFO_CNT_BITS-1:0] count_reg, count_next;
    logic                     pop;

    assign m_valid = (count_reg != '0);
    assign m_data  = mem[rd_ptr_reg];
    assign pop     = m_valid && m_ready;
    // always space for the worst case of two results
    assign room    = (count_reg <= FIFO_CNT_BITS'(FIFO_DEPTH - 2));

    always_comb begin
        wr_ptr_next = wr_ptr_reg + FIFO_PTR_BITS'(push.count);
        rd_ptr_next = rd_ptr_reg + FIFO_PTR_BITS'(pop);
        count_next  = count_reg + FIFO_CNT_BITS'(push.count) - FIFO_CNT_BITS'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push.count != 2'd0) begin
            mem[wr_ptr_reg] <= push.first;
        end
        if (push.count == 2'd2) begin
            mem[wr_ptr_reg + FIFO_PTR_BITS'(1)] <= push.second;
        end
    end

`ifndef SYNTH
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= FIFO_CNT_BITS'(FIFO_DEPTH))
        else $error("result queue over-filled");

    a_push_room: assert property (@(posedge aclk) disable iff (!aresetn)
        (push.count != 2'd0) |-> room)
        else $error("results pushed without room");
`endif

endmodule

`default_nettype wire

// ===== rtl/dst_core.sv =====
// Per-byte state update: window shift, positions, match and field results.
// Depends on dst_pkg and dst_match.
`default_nettype none

module dst_core #(
    parameter int MAX_DELIMITER_BYTES = 8,
    parameter int POSITION_BITS       = 16,
    parameter int LEN_W               = 4
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                in_fire,
    input  wire dst_pkg::in_item_t                   item,
    input  wire logic [MAX_DELIMITER_BYTES-1:0][7:0] delim,
    input  wire logic [LEN_W-1:0]                    len,
    output dst_pkg::push_t                           push
);
    import dst_pkg::*;

    localparam int POS_W = POSITION_BITS;
    localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};
    localparam logic [LEN_W-1:0] RUN_CAP = LEN_W'(MAX_DELIMITER_BYTES);

    logic [MAX_DELIMITER_BYTES-1:0][7:0] win_reg, win_next, win_shift;
    logic [POS_W-1:0] pos_reg, pos_next, pos_b, pos_a;
    logic [POS_W-1:0] fstart_reg, fstart_next, fstart_a;
    logic             ovf_reg, ovf_next, ovf_b, ovf_a;
    logic [LEN_W-1:0] run_reg, run_next, run_b, run_a;

    logic             present, endi, hit, match;
    logic [POS_W:0]   mend_diff, flen_m_diff, flen_e_diff;
    logic [POS_W-1:0] mend, flen_m, flen_e;
    result_t          match_res, end_res;

    dst_match #(
        .MAX_DELIMITER_BYTES (MAX_DELIMITER_BYTES),
        .LEN_W               (LEN_W)
    ) u_match (
        .window (win_shift),
        .delim  (delim),
        .len    (len),
        .hit    (hit)
    );

    always_comb begin
        present = in_fire && item.byte_present;
        endi    = in_fire && item.end_of_string;

        win_shift[0] = item.data_byte;
        for (int j = 1; j < MAX_DELIMITER_BYTES; j++) begin
            win_shift[j] = win_reg[j-1];
        end

        pos_b = (pos_reg == POS_MAX) ? pos_reg : pos_reg + POS_W'(1);
        ovf_b = ovf_reg || (pos_reg == POS_MAX);
        run_b = (run_reg < RUN_CAP) ? run_reg + LEN_W'(1) : run_reg;

        // a match must lie wholly inside the current field
        match = present && (len != '0) && (run_b >= len) && hit;

        mend_diff   = {1'b0, pos_b} - {1'b0, POS_W'(len)};
        mend        = mend_diff[POS_W] ? '0 : mend_diff[POS_W-1:0];
        flen_m_diff = {1'b0, mend} - {1'b0, fstart_reg};
        flen_m      = flen_m_diff[POS_W] ? '0 : flen_m_diff[POS_W-1:0];

        if (present) begin
            win_next = win_shift;
            pos_a    = pos_b;
            ovf_a    = ovf_b;
            run_a    = match ? '0 : run_b;
            fstart_a = match ? pos_b : fstart_reg;
        end else begin
            win_next = win_reg;
            pos_a    = pos_reg;
            ovf_a    = ovf_reg;
            run_a    = run_reg;
            fstart_a = fstart_reg;
        end

        flen_e_diff = {1'b0, pos_a} - {1'b0, fstart_a};
        flen_e      = flen_e_diff[POS_W] ? '0 : flen_e_diff[POS_W-1:0];

        match_res.field_start       = FIELD_BITS'(fstart_reg);
        match_res.field_length      = FIELD_BITS'(flen_m);
        match_res.last_field        = 1'b0;
        match_res.position_overflow = ovf_a;

        end_res.field_start         = FIELD_BITS'(fstart_a);
        end_res.field_length        = FIELD_BITS'(flen_e);
        end_res.last_field          = 1'b1;
        end_res.position_overflow   = ovf_a;

        push.count  = {1'b0, match} + {1'b0, endi};
        push.first  = match ? match_res : end_res;
        push.second = end_res;

        if (endi) begin
            win_next    = '0;
            pos_next    = '0;
            fstart_next = '0;
            ovf_next    = 1'b0;
            run_next    = '0;
        end else begin
            pos_next    = pos_a;
            fstart_next = fstart_a;
            ovf_next    = ovf_a;
            run_next    = run_a;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            win_reg    <= '0;
            pos_reg    <= '0;
            fstart_reg <= '0;
            ovf_reg    <= 1'b0;
            run_reg    <= '0;
        end else begin
            win_reg    <= win_next;
            pos_reg    <= pos_next;
            fstart_reg <= fstart_next;
            ovf_reg    <= ovf_next;
            run_reg    <= run_next;
        end
    end

`ifndef SYNTH
    a_start_behind_pos: assert property (@(posedge aclk) disable iff (!aresetn)
        fstart_reg <= pos_reg)
        else $error("field start ahead of byte position");

    a_ovf_saturated: assert property (@(posedge aclk) disable iff (!aresetn)
        ovf_reg |-> (pos_reg == POS_MAX))
        else $error("overflow flagged without saturated position");

    a_end_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        endi |=> (pos_reg == '0) && (fstart_reg == '0) && !ovf_reg && (run_reg == '0))
        else $error("string state not cleared after end of string");
`endif

endmodule

`default_nettype wire

// ===== rtl/delimiter_split_tokenizer.sv =====
// Delimiter split tokenizer, top level.
// Depends on dst_pkg, dst_core, dst_match and dst_fifo.
//
// Use: bytes of a string arrive on the s_ channel, one beat per item, with
// byte_present and end_of_string flags. Every completed delimiter match gives
// one result on the m_ channel (start and length of the field before it); the
// item closing the string gives the final field with last_field set, so one
// beat in can give zero, one or two beats out.
// The delimiter (up to MAX_DELIMITER_BYTES bytes) and its length are set over
// the cfg_ channel, index 0 for the bytes and 1 for the length; cfg_ready is
// always high. Write it only while the block is idle.
// Output: each result is written into the queue when its item is accepted and
// is offered on m_ once the results ahead of it are taken. Throughput: one item
// per cycle while s_ready is high, as the window compare and position update are
// combinational; the output side moves one result per beat, so strings with many
// short fields are paced by m_ready. Stall: results wait in a four-entry queue;
// s_ready drops while fewer than two entries are free, and returns when two are.
// Reset: synchronous, active low; queue empty, string state clear, delimiter
// back to a single comma.
`default_nettype none

module delimiter_split_tokenizer #(
    parameter int MAX_DELIMITER_BYTES = 8,
    parameter int POSITION_BITS       = 16
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,

    input  wire logic                                s_valid,
    output logic                                     s_ready,
    input  wire dst_pkg::in_item_t                   s_data,

    output logic                                     m_valid,
    input  wire logic                                m_ready,
    output dst_pkg::result_t                         m_data,

    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [dst_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  wire logic [dst_pkg::CFG_DATA_BITS-1:0]   cfg_data
);
    import dst_pkg::*;

    localparam int LEN_W   = $clog2(MAX_DELIMITER_BYTES + 1);
    localparam int DELIM_W = 8 * MAX_DELIMITER_BYTES;

    logic [DELIM_W-1:0]      delim_reg;
    logic [LEN_REG_BITS-1:0] dlen_reg;
    logic [LEN_W-1:0]        len_act;
    logic                    in_fire;
    logic                    room;
    push_t                   push;

    assign cfg_ready = 1'b1;
    assign s_ready   = room;
    assign in_fire   = s_valid && s_ready;

    // lengths past the window act as the full window
    assign len_act = (dlen_reg > LEN_REG_BITS'(MAX_DELIMITER_BYTES)) ?
                     LEN_W'(MAX_DELIMITER_BYTES) : LEN_W'(dlen_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            delim_reg <= DELIM_W'(DELIM_BYTES_RESET);
            dlen_reg  <= DELIM_LEN_RESET;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_DELIMITER_BYTES:  delim_reg <= cfg_data[DELIM_W-1:0];
                CFG_DELIMITER_LENGTH: dlen_reg  <= cfg_data[LEN_REG_BITS-1:0];
                default: ;
            endcase
        end
    end

    dst_core #(
        .MAX_DELIMITER_BYTES (MAX_DELIMITER_BYTES),
        .POSITION_BITS       (POSITION_BITS),
        .LEN_W               (LEN_W)
    ) u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .in_fire (in_fire),
        .item    (s_data),
        .delim   (delim_reg),
        .len     (len_act),
        .push    (push)
    );

    dst_fifo u_fifo (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .room    (room),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

`default_nettype wire

// ===== dv/tb_delimiter_split_tokenizer.sv =====
// Self-checking testbench for delimiter_split_tokenizer: directed table, then random strings.
// Expected fields come from typed table rows or a cycle-free splitter model kept in this file.
// Depends on dst_pkg and the RTL of the block only.
module tb_delimiter_split_tokenizer;
    import dst_pkg::*;

    localparam int          MAXD          = 8;
    localparam int unsigned POS_LIMIT     = 32'd65535;
    localparam int          SETTLE_CYCLES = 4;
    localparam int          DRAIN_CYCLES  = 16;
    localparam int          HOLD_CYCLES   = 300;
    localparam int          PHASE_BEATS   = 150;
    localparam int          RUN_LIMIT     = 2_000_000;
    localparam int          MAX_PRINTS    = 40;

    typedef enum logic {ROW_BEAT, ROW_WRITE} row_kind_t;
    typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_ONE_IN_FOUR, RX_MOSTLY} rx_mode_t;

    typedef struct packed {
        row_kind_t                 kind;
        logic [CFG_INDEX_BITS-1:0] reg_index;
        logic [CFG_DATA_BITS-1:0]  reg_value;
        in_item_t                  beat;
        logic                      use_model;
        logic [1:0]                n_typed;
        result_t                   first;
        result_t                   second;
    } plan_row_t;

    localparam result_t NONE = '0;
    localparam int NUM_ROWS = 30;

    // Typed rows: empty string, delimiter at both ends, extremes of the byte,
    // an ignored beat, near-start rejection, zero length; the oversize length rows use the model.
    localparam plan_row_t DIRECTED_PLAN [NUM_ROWS] = '{
        '{ROW_BEAT,  4'd0, 64'd0, '{8'h00, 1'b0, 1'b1}, 1'b0, 2'd1,
          '{16'd0, 16'd0, 1'b1, 1'b0}, NONE},
        '{ROW_BEAT,  4'd0, 64'd0, '{8'h2C, 1'b1, 1'b1}, 1'b0, 2'd2,
          '{16'd0, 16'd0, 1'b0, 1'b0}, '{16'd1, 16'd0, 1'b1, 1'b0}},
        '{ROW_BEAT,  4'd0, 64'd0, '{8'h61, 1'b1, 1'b0}, 1'b0, 2'd0, NONE, NONE},
        '{ROW_BEAT,  4'd0, 64'd0, '{8'h2C, 1'b1, 1'b0}, 1'b0, 2'd1,
          '{16'd0, 16'd1, 1'b0, 1'b0}, NONE},
        '{ROW_BEAT,  4'd0, 64'd0, '{8'hFF, 1'b1, 1'b0}, 1'b0, 2'd0, NONE, NONE},
        '{ROW_BEAT,  4'd0, 64'd0, '{8'hFF, 1'b0, 1'b0}, 1'b0, 2'd0, NONE, NONE},
        '{ROW_BEAT,  4'd0, 64'd0, '{8'h00, 1'b1, 1'b1}, 1'b0, 2'd1,
          '{16'd2, 16'd2, 1'b1, 1'b0}, NONE},
        '{ROW_WRITE, CFG_DELIMITER_BYTES, 64'h6261, '0, 1'b0, 2'd0, NONE, NONE},
        '{ROW_WRITE, CFG_DELIMITER_LENGTH, 64'd2, '0, 1'b0, 2'd0, NONE, NONE},
        '{ROW_BEAT,  4'd0, 64'd0, '{8'h61, 1'b1, 1'b1}, 1'b0, 2'd1,
          '{16'd0, 16'd1, 1'b1, 1'b0}, NONE},
        '{ROW_BEAT,  4'd0, 64'd0, '{8'h62, 1'b1, 1'b0}, 1'b0, 2'd0, NONE, NONE},
        '{ROW_BEAT,  4'd0, 64'd0, '{8'h61, 1'b1, 1'b0}, 1'b1, 2'd0, NONE, NONE},
        '{ROW_BEAT,  4'd0, 64'd0, '{8'h62, 1'b1, 1'b0}, 1'b1, 2'd0, NONE, NONE},
        '{ROW_BEAT,  4'd0, 64'd0, '{8'h61, 1'b1, 1'b0}, 1'b1, 2'd0, NONE, NONE},
        '{ROW_BEAT,  4'd0, 64'd0, '{8'h62, 1'b1, 1'b1}, 1'b1, 2'd0, NONE, NONE},
        '{ROW_WRITE, CFG_DELIMITER_LENGTH, 64'd0, '0, 1'b0, 2'd0, NONE, NONE},
        '{ROW_BEAT,  4'd0, 64'd0, '{8'h61, 1'b1, 1'b0}, 1'b0, 2'd0, NONE, NONE},
        '{ROW_BEAT,  4'd0, 64'd0, '{8'h2C, 1'b1, 1'b0}, 1'b0, 2'd0, NONE, NONE},
        '{ROW_BEAT,  4'd0, 64'd0, '{8'h00, 1'b0, 1'b1}, 1'b0, 2'd1,
          '{16'd0, 16'd2, 1'b1, 1'b0}, NONE},
        '{ROW_WRITE, CFG_DELIMITER_BYTES, 64'h0807_0605_0403_0201, '0, 1'b0, 2'd0,
          NONE, NONE},
        '{ROW_WRITE, CFG_DELIMITER_LENGTH, 64'hFFFF_FFFF_FFFF_FFFF, '0, 1'b0, 2'd0,
          NONE, NONE},
        '{ROW_BEAT,  4'd0, 64'd0, '{8'h01, 1'b1, 1'b0}, 1'b1, 2'd0, NONE, NONE},
        '{ROW_BEAT,  4'd0, 64'd0, '{8'h02, 1'b1, 1'b0}, 1'b1, 2'd0, NONE, NONE},
        '{ROW_BEAT,  4'd0, 64'd0, '{8'h03, 1'b1, 1'b0}, 1'b1, 2'd0, NONE, NONE},
        '{ROW_BEAT,  4'd0, 64'd0, '{8'h04, 1'b1, 1'b0}, 1'b1, 2'd0, NONE, NONE},
        '{ROW_BEAT,  4'd0, 64'd0, '{8'h05, 1'b1, 1'b0}, 1'b1, 2'd0, NONE, NONE},
        '{ROW_BEAT,  4'd0, 64'd0, '{8'h06, 1'b1, 1'b0}, 1'b1, 2'd0, NONE, NONE},
        '{ROW_BEAT,  4'd0, 64'd0, '{8'h07, 1'b1, 1'b0}, 1'b1, 2'd0, NONE, NONE},
        '{ROW_BEAT,  4'd0, 64'd0, '{8'h08, 1'b1, 1'b0}, 1'b1, 2'd0, NONE, NONE},
        '{ROW_BEAT,  4'd0, 64'd0, '{8'h00, 1'b1, 1'b1}, 1'b1, 2'd0, NONE, NONE}
    };

    logic                      aclk      = 1'b0;
    logic                      aresetn   = 1'b0;
    logic                      s_valid   = 1'b0;
    logic                      s_ready;
    in_item_t                  s_data    = '0;
    logic                      m_valid;
    logic                      m_ready   = 1'b0;
    result_t                   m_data;
    logic                      cfg_valid = 1'b0;
    logic                      cfg_ready;
    logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
    logic [CFG_DATA_BITS-1:0]  cfg_data  = '0;

    delimiter_split_tokenizer uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #2 aclk = ~aclk;

    // splitter model state and register mirror
    logic [7:0]               hist [8];
    int unsigned              pos_ctr, fstart, run_ctr;
    logic                     ovf_seen;
    logic [CFG_DATA_BITS-1:0] delim_reg     = DELIM_BYTES_RESET;
    logic [LEN_REG_BITS-1:0]  delim_len_reg = DELIM_LEN_RESET;

    result_t expected_fields [$];
    int      mismatches     = 0;
    int      fields_checked = 0;
    int      beats_in       = 0;
    int      strings_closed = 0;
    int      reg_writes     = 0;
    int      cycles         = 0;
    int      burst_left     = 0;
    int      gap_max        = 6;
    bit      hold_request   = 1'b0;

    task automatic report_mismatch(input string what, input logic [15:0] got,
                                   input logic [15:0] want);
        if (mismatches < MAX_PRINTS)
            $display("mismatch at cycle %0d: %s got %0d expected %0d", cycles, what, got, want);
        mismatches++;
    endtask

    function automatic void queue_field(input result_t r);
        expected_fields = {expected_fields, r};
    endfunction

    function automatic in_item_t make_beat(input logic [7:0] b, input logic present,
                                           input logic closes);
        in_item_t it;
        it.data_byte     = b;
        it.byte_present  = present;
        it.end_of_string = closes;
        return it;
    endfunction

    function automatic result_t field_result(input int unsigned start, input int unsigned len,
                                             input logic last);
        result_t r;
        r.field_start       = start[15:0];
        r.field_length      = len[15:0];
        r.last_field        = last;
        r.position_overflow = ovf_seen;
        return r;
    endfunction

    function automatic int unsigned active_len();
        return (delim_len_reg > MAXD) ? MAXD : delim_len_reg;
    endfunction

    function automatic void clear_string();
        foreach (hist[j]) hist[j] = 8'h00;
        pos_ctr  = 0;
        fstart   = 0;
        run_ctr  = 0;
        ovf_seen = 1'b0;
    endfunction

    // One accepted beat through the splitter; returns how many fields it closes.
    function automatic int split_step(input in_item_t it, output result_t r0,
                                      output result_t r1);
        int          n;
        int unsigned eff, mend, flen;
        logic        hit;
        n   = 0;
        r0  = '0;
        r1  = '0;
        eff = active_len();
        if (it.byte_present) begin
            for (int j = 7; j > 0; j--) hist[j] = hist[j-1];
            hist[0] = it.data_byte;
            if (pos_ctr >= POS_LIMIT) begin
                pos_ctr  = POS_LIMIT;
                ovf_seen = 1'b1;
            end else begin
                pos_ctr++;
            end
            if (run_ctr < MAXD) run_ctr++;
            hit = (eff > 0) && (run_ctr >= eff);
            for (int j = 0; j < eff; j++)
                if (hist[j] != delim_reg[8*(eff-1-j) +: 8]) hit = 1'b0;
            if (hit) begin
                mend    = (pos_ctr >= eff) ? pos_ctr - eff : 0;
                flen    = (mend >= fstart) ? mend - fstart : 0;
                r0      = field_result(fstart, flen, 1'b0);
                n       = 1;
                fstart  = pos_ctr;
                run_ctr = 0;
            end
        end
        if (it.end_of_string) begin
            flen = (pos_ctr >= fstart) ? pos_ctr - fstart : 0;
            if (n == 0) r0 = field_result(fstart, flen, 1'b1);
            else        r1 = field_result(fstart, flen, 1'b1);
            n++;
            clear_string();
        end
        return n;
    endfunction

    // Offer one beat, with the sender's burst and gap pattern; returns once accepted.
    task automatic offer_beat(input in_item_t it);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 32);
            gap        = $urandom_range(0, gap_max);
            if (gap != 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_valid <= 1'b1;
        s_data  <= it;
        do @(posedge aclk); while (!s_ready);
        if (it.byte_present || it.end_of_string) beats_in++;
        if (it.end_of_string) strings_closed++;
    endtask

    task automatic stream_beat(input in_item_t it);
        result_t r0, r1;
        int      n;
        offer_beat(it);
        n = split_step(it, r0, r1);
        if (n > 0) queue_field(r0);
        if (n > 1) queue_field(r1);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] val);
        s_valid <= 1'b0;
        while (expected_fields.size() != 0) @(posedge aclk);
        // a beat with no field may still be in flight
        repeat (SETTLE_CYCLES) @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        reg_writes++;
        if (idx == CFG_DELIMITER_BYTES)
            delim_reg = val;
        else if (idx == CFG_DELIMITER_LENGTH)
            delim_len_reg = val[LEN_REG_BITS-1:0];
        burst_left = 0;
    endtask

    // Strings built mostly from delimiter bytes, whole or cut short, plus noise beats.
    task automatic random_phase(input logic [CFG_DATA_BITS-1:0] bytes_val,
                                input logic [LEN_REG_BITS-1:0] len_val,
                                input int budget, input bit with_hold);
        logic [CFG_DATA_BITS-1:0] v;
        int                       sent, slen, k, eff, cut;
        sent = 0;
        v    = {$urandom, $urandom};
        v[LEN_REG_BITS-1:0] = len_val;
        write_reg(CFG_DELIMITER_BYTES, bytes_val);
        write_reg(CFG_DELIMITER_LENGTH, v);
        eff = active_len();
        while (sent < budget) begin
            slen = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 14);
            for (int i = 0; i < slen; i++) begin
                k = $urandom_range(0, 9);
                if (k < 3 && eff > 0) begin
                    cut = (k == 2) ? $urandom_range(1, eff) : eff;
                    for (int j = 0; j < cut; j++)
                        stream_beat(make_beat(delim_reg[8*j +: 8], 1'b1, 1'b0));
                    sent += cut;
                end else if (k < 6 && eff > 0) begin
                    stream_beat(make_beat(delim_reg[8*$urandom_range(0, eff-1) +: 8], 1'b1, 1'b0));
                    sent++;
                end else begin
                    stream_beat(make_beat(8'($urandom_range(0, 255)), 1'b1, 1'b0));
                    sent++;
                end
                if ($urandom_range(0, 11) == 0)
                    stream_beat(make_beat(8'($urandom_range(0, 255)), 1'b0, 1'b0));
                if (with_hold && sent >= 60 && sent < 70) hold_request = 1'b1;
            end
            if ($urandom_range(0, 2) == 0)
                stream_beat(make_beat(8'($urandom_range(0, 255)), 1'b0, 1'b1));
            else if (eff > 0 && $urandom_range(0, 1) == 0)
                stream_beat(make_beat(delim_reg[8*(eff-1) +: 8], 1'b1, 1'b1));
            else
                stream_beat(make_beat(8'($urandom_range(0, 255)), 1'b1, 1'b1));
            sent++;
        end
    endtask

    // receiver: stall modes that change at random, plus long holds requested by the sender
    initial begin
        rx_mode_t mode;
        int       mode_left, tick;
        mode      = RX_OPEN;
        mode_left = 0;
        tick      = 0;
        wait (aresetn);
        forever begin
            if (hold_request) begin
                hold_request = 1'b0;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end
            if (mode_left == 0) begin
                mode      = rx_mode_t'($urandom_range(0, 3));
                mode_left = $urandom_range(16, 96);
            end
            mode_left--;
            tick++;
            case (mode)
                RX_OPEN:        m_ready <= 1'b1;
                RX_COIN:        m_ready <= 1'($urandom_range(0, 1));
                RX_ONE_IN_FOUR: m_ready <= (tick % 4 == 0);
                default:        m_ready <= ($urandom_range(0, 7) != 0);
            endcase
            @(posedge aclk);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (expected_fields.size() == 0) begin
                report_mismatch("unexpected field, start", m_data.field_start, 16'd0);
            end else begin
                result_t want;
                want = expected_fields.pop_front();
                fields_checked++;
                if (m_data.field_start !== want.field_start)
                    report_mismatch("field_start", m_data.field_start, want.field_start);
                if (m_data.field_length !== want.field_length)
                    report_mismatch("field_length", m_data.field_length, want.field_length);
                if (m_data.last_field !== want.last_field)
                    report_mismatch("last_field", 16'(m_data.last_field), 16'(want.last_field));
                if (m_data.position_overflow !== want.position_overflow)
                    report_mismatch("position_overflow", 16'(m_data.position_overflow),
                                    16'(want.position_overflow));
            end
        end
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= RUN_LIMIT) begin
            $display("timeout after %0d cycles, %0d fields outstanding",
                     cycles, expected_fields.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial begin
        plan_row_t row;
        result_t   r0, r1;
        int        n;
        clear_string();
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (DIRECTED_PLAN[i]) begin
            row = DIRECTED_PLAN[i];
            if (row.kind == ROW_WRITE) begin
                write_reg(row.reg_index, row.reg_value);
            end else begin
                offer_beat(row.beat);
                n = split_step(row.beat, r0, r1);
                if (!row.use_model) begin
                    n  = row.n_typed;
                    r0 = row.first;
                    r1 = row.second;
                end
                if (n > 0) queue_field(r0);
                if (n > 1) queue_field(r1);
            end
        end

        random_phase(64'd44, 4'd1, PHASE_BEATS, 1'b1);
        random_phase({$urandom, $urandom}, 4'd2, PHASE_BEATS, 1'b0);
        random_phase(64'd0, 4'd3, PHASE_BEATS, 1'b0);
        random_phase('1, 4'd8, PHASE_BEATS, 1'b0);
        random_phase({$urandom, $urandom}, 4'd0, PHASE_BEATS, 1'b0);
        // index with no register behind it: must change nothing
        write_reg(CFG_INDEX_BITS'($urandom_range(12, 15)), {$urandom, $urandom});
        random_phase({$urandom, $urandom}, LEN_REG_BITS'($urandom_range(9, 15)),
                     PHASE_BEATS, 1'b0);
        random_phase(64'h4141_4141_4141_4141, 4'd4, PHASE_BEATS, 1'b0);
        random_phase({$urandom, $urandom}, 4'd1, PHASE_BEATS, 1'b0);
        random_phase({$urandom, $urandom}, LEN_REG_BITS'($urandom_range(1, 8)),
                     PHASE_BEATS, 1'b0);

        s_valid <= 1'b0;
        while (expected_fields.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Sent %0d beats in %0d strings, checked %0d fields, %0d register writes.",
                 beats_in, strings_closed, fields_checked, reg_writes);
        $display("Delimiters of length 0 to 15, partial matches, empty and one-byte strings.");
        if (mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/dst_pkg.sv
rtl/dst_match.sv
rtl/dst_fifo.sv
rtl/dst_core.sv
rtl/delimiter_split_tokenizer.sv
dv/tb_delimiter_split_tokenizer.sv
